[src/amms_pkg.sv]
// Shared types and constants for the running min/max/mean statistics block.
// No dependencies; every other file imports this package.
`default_nettype none

package amms_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned INDEX_W = 16;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] mean;
		logic signed [VALUE_W-1:0] max_value;
		logic [INDEX_W-1:0]        max_idx;
		logic signed [VALUE_W-1:0] min_value;
		logic [INDEX_W-1:0]        min_idx;
		logic [VALUE_W-1:0]        value_range;
		logic                      overflow;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP_MAX,
		S_CMP_MIN,
		S_ADD,
		S_RANGE,
		S_ABS,
		S_DIV,
		S_SIGN
	} state_t;

endpackage

`default_nettype wire

[src/amms_if.sv]
// Valid/ready stream interfaces for the item input and the result output.
// Depends on amms_pkg for the payload types.
`default_nettype none

interface amms_item_if import amms_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface amms_result_if import amms_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/array_min_max_mean_stats.sv]
// Running min/max/mean statistics over a stream of signed 32-bit values.
// Depends on amms_pkg and the stream interfaces in amms_if.sv.
//
//   channel   dir   payload                                        beat when
//   -------   ---   --------------------------------------------   ------------------
//   item      in    value (s32), last                              valid && ready
//   result    out   mean, max/min value+index, value_range, ovf    valid && ready
//
// Sequencing: one adder of SW+1 bits (SW = 32 + clog2(MAX_ITEMS)) does every add,
// compare and subtract in turn. A discarded (overflowing) beat is only accepted,
// the first beat of an array is accepted and accumulated, every other beat goes
// through accept, max compare, min compare and accumulate. A last beat then adds
// range, magnitude, SW restoring division steps and sign.
// Reset: arst_n clears the sequencer, the statistics and the result valid.
// Stalls: the result sits in an output register; new beats are taken while it
// waits, and only the final sign step holds until that register is free.
`default_nettype none

module array_min_max_mean_stats import amms_pkg::*; #(
	parameter int unsigned MAX_ITEMS = 65536
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	amms_item_if.sink      item,
	amms_result_if.source  result
);

	// Widths follow from the item limit: the sum never wraps, the count can
	// hold the limit itself, positions stop one below it.
	localparam int unsigned SW  = VALUE_W + $clog2(MAX_ITEMS);
	localparam int unsigned AW  = SW + 1;
	localparam int unsigned CW  = $clog2(MAX_ITEMS + 1);
	localparam int unsigned PW  = $clog2(MAX_ITEMS);
	localparam int unsigned XW  = (PW > INDEX_W) ? PW : INDEX_W;
	localparam int unsigned SCW = $clog2(SW + 1);

	state_t state_q, state_d;

	logic signed [VALUE_W-1:0] val_q;
	logic                      last_q;
	logic signed [SW-1:0]      sum_q;
	logic signed [VALUE_W-1:0] max_q, min_q;
	logic [PW-1:0]             max_pos_q, min_pos_q;
	logic [CW-1:0]             cnt_q;
	logic                      ovf_q;
	logic [VALUE_W-1:0]        range_q;
	logic                      neg_q;
	logic [SW-1:0]             div_q;
	logic [CW-1:0]             rem_q;
	logic [SCW-1:0]            step_q;
	logic                      out_valid_q;
	result_t                   out_q;

	// Shared adder/subtractor
	logic [AW-1:0] alu_a, alu_b, alu_res;
	logic          alu_sub;

	logic          accept;
	logic          cnt_full, cnt_empty;
	logic          load_ok, load_out;
	logic [CW:0]   rem_shift;
	logic          qbit;

	function automatic logic [INDEX_W-1:0] sat_pos(input logic [PW-1:0] p);
		logic [XW-1:0] pe;
		pe = XW'(p);
		return (pe > XW'(16'hFFFF)) ? 16'hFFFF : pe[INDEX_W-1:0];
	endfunction

	assign accept    = item.valid && item.ready;
	assign cnt_full  = (cnt_q == CW'(MAX_ITEMS));
	assign cnt_empty = (cnt_q == '0);
	assign load_ok   = !out_valid_q || result.ready;
	assign load_out  = (state_q == S_SIGN) && load_ok;

	assign rem_shift = {rem_q, div_q[SW-1]};
	assign alu_res   = alu_a + (alu_sub ? ~alu_b : alu_b) + AW'(alu_sub);
	assign qbit      = !alu_res[AW-1];

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					priority if (cnt_full)
						state_d = item.data.last ? S_RANGE : S_IDLE;
					else if (cnt_empty)
						state_d = S_ADD;
					else
						state_d = S_CMP_MAX;
				end
			end
			S_CMP_MAX: state_d = S_CMP_MIN;
			S_CMP_MIN: state_d = S_ADD;
			S_ADD:     state_d = last_q ? S_RANGE : S_IDLE;
			S_RANGE:   state_d = S_ABS;
			S_ABS:     state_d = S_DIV;
			S_DIV:     state_d = (step_q == SCW'(1)) ? S_SIGN : S_DIV;
			S_SIGN:    state_d = load_ok ? S_IDLE : S_SIGN;
			default:   state_d = S_IDLE;
		endcase
	end

	// Adder operand selection and handshake outputs
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			S_CMP_MAX: begin
				// max - v < 0 means a new maximum
				alu_a   = {{(AW-VALUE_W){max_q[VALUE_W-1]}}, max_q};
				alu_b   = {{(AW-VALUE_W){val_q[VALUE_W-1]}}, val_q};
				alu_sub = 1'b1;
			end
			S_CMP_MIN: begin
				// v - min < 0 means a new minimum
				alu_a   = {{(AW-VALUE_W){val_q[VALUE_W-1]}}, val_q};
				alu_b   = {{(AW-VALUE_W){min_q[VALUE_W-1]}}, min_q};
				alu_sub = 1'b1;
			end
			S_ADD: begin
				alu_a = {sum_q[SW-1], sum_q};
				alu_b = {{(AW-VALUE_W){val_q[VALUE_W-1]}}, val_q};
			end
			S_RANGE: begin
				alu_a   = {{(AW-VALUE_W){max_q[VALUE_W-1]}}, max_q};
				alu_b   = {{(AW-VALUE_W){min_q[VALUE_W-1]}}, min_q};
				alu_sub = 1'b1;
			end
			S_ABS: begin
				// negate a negative sum, pass a positive one
				alu_b   = {sum_q[SW-1], sum_q};
				alu_sub = sum_q[SW-1];
			end
			S_DIV: begin
				alu_a   = AW'(rem_shift);
				alu_b   = AW'(cnt_q);
				alu_sub = 1'b1;
			end
			S_SIGN: begin
				alu_b   = AW'(div_q);
				alu_sub = neg_q;
			end
			default: ;
		endcase
	end

	assign item.ready   = (state_q == S_IDLE);
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// Control and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sum_q       <= '0;
			max_q       <= '0;
			min_q       <= '0;
			max_pos_q   <= '0;
			min_pos_q   <= '0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			neg_q       <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						priority if (cnt_full) begin
							// drop the beat, flag it
							ovf_q <= 1'b1;
						end else if (cnt_empty) begin
							max_q     <= item.data.value;
							min_q     <= item.data.value;
							max_pos_q <= '0;
							min_pos_q <= '0;
						end else begin
							// later beats: the compare states update the extremes
						end
					end
				end
				S_CMP_MAX: begin
					if (alu_res[AW-1]) begin
						max_q     <= val_q;
						max_pos_q <= cnt_q[PW-1:0];
					end
				end
				S_CMP_MIN: begin
					if (alu_res[AW-1]) begin
						min_q     <= val_q;
						min_pos_q <= cnt_q[PW-1:0];
					end
				end
				S_ADD: begin
					sum_q <= alu_res[SW-1:0];
					cnt_q <= cnt_q + CW'(1);
				end
				S_ABS: begin
					neg_q  <= sum_q[SW-1];
					step_q <= SCW'(SW);
				end
				S_DIV: begin
					step_q <= step_q - SCW'(1);
				end
				S_SIGN: begin
					if (load_ok) begin
						// array done: back to the reset statistics
						sum_q     <= '0;
						max_q     <= '0;
						min_q     <= '0;
						max_pos_q <= '0;
						min_pos_q <= '0;
						cnt_q     <= '0;
						ovf_q     <= 1'b0;
					end
				end
				default: ;
			endcase

			priority if (load_out)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
			else
				out_valid_q <= out_valid_q;
		end
	end

	// Datapath payload
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q  <= item.data.value;
			last_q <= item.data.last;
		end
		if (state_q == S_RANGE)
			range_q <= alu_res[VALUE_W-1:0];
		if (state_q == S_ABS) begin
			div_q <= alu_res[SW-1:0];
			rem_q <= '0;
		end
		if (state_q == S_DIV) begin
			// restoring step: shift in next dividend bit, keep trial if non-negative
			div_q <= {div_q[SW-2:0], qbit};
			rem_q <= qbit ? alu_res[CW-1:0] : rem_shift[CW-1:0];
		end
		if (load_out) begin
			out_q.mean        <= alu_res[VALUE_W-1:0];
			out_q.max_value   <= max_q;
			out_q.max_idx     <= sat_pos(max_pos_q);
			out_q.min_value   <= min_q;
			out_q.min_idx     <= sat_pos(min_pos_q);
			out_q.value_range <= range_q;
			out_q.overflow    <= ovf_q;
		end
	end

endmodule

`default_nettype wire

[src/amms_checker.sv]
// Port-level assertions for array_min_max_mean_stats, bound to the top level.
// Depends on amms_pkg for the result payload type.
`default_nettype none

module amms_checker import amms_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    item_valid,
	input wire logic    item_ready,
	input wire logic    item_last,
	input wire logic    result_valid,
	input wire logic    result_ready,
	input wire result_t result_data
);

	// Held result must not change under back-pressure.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_data))
		else $error("result changed while stalled");

	// The block is busy finishing an array right after its last beat.
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_last |=> !item_ready)
		else $error("ready right after last beat");

	a_extremes_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $signed(result_data.max_value) >= $signed(result_data.min_value))
		else $error("max below min");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
			result_data.value_range == result_data.max_value - result_data.min_value)
		else $error("range mismatch");

	// All elements equal: both indices point at the first one, mean is that value.
	a_flat_array: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.max_value == result_data.min_value |->
			result_data.max_idx == '0 && result_data.min_idx == '0 &&
			result_data.mean == result_data.max_value)
		else $error("flat array result inconsistent");

endmodule

bind array_min_max_mean_stats amms_checker u_amms_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_last    (item.data.last),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  (result.data)
);

`default_nettype wire

[tb/tb_top.sv]
// Self-checking bench for array_min_max_mean_stats: random and directed arrays
// in, mean/min/max/range results checked against an in-bench predictor.
// Depends on amms_pkg and the stream interfaces in amms_if.sv.
`default_nettype none

module tb_top;
	import amms_pkg::*;

	localparam int unsigned MAX_ITEMS = 65536;
	// Quiet cycles tolerated before the run is declared hung. A last beat adds
	// the division steps and the idle phases add random gaps, so this leaves a
	// wide margin.
	localparam int QUIET_LIMIT = 4000;
	// Cycles to keep watching after the final result, to catch stray beats.
	localparam int TAIL_CYCLES = 80;
	localparam int RANDOM_PER_PHASE = 300;
	localparam int LONG_LEN = 48;
	localparam logic signed [VALUE_W-1:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] S32_MAX = 32'sh7fff_ffff;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	amms_item_if   item_ch ();
	amms_result_if result_ch ();

	array_min_max_mean_stats #(.MAX_ITEMS(MAX_ITEMS)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	always #1 clk = ~clk;

	// Beats waiting to be driven, and results the predictor says must come.
	item_t   pending_q[$];
	result_t stats_q[$];

	// Per-phase idle rates, in percent of cycles.
	int send_idle_pct = 0;
	int stall_pct = 0;

	// Predictor state: one open array at a time.
	longint sum_acc = 0;
	longint hi_val = 0;
	longint lo_val = 0;
	longint hi_pos = 0;
	longint lo_pos = 0;
	longint n_taken = 0;
	bit     ovf_seen = 1'b0;

	int  err_count = 0;
	int  err_shown = 0;
	int  results_checked = 0;
	int  arrays_queued = 0;
	int  values_queued = 0;
	int  quiet_cycles = 0;
	logic item_beat = 1'b0;

	// Fold one accepted value into the open array; close it on last.
	function automatic void fold_value(item_t it);
		result_t r;
		longint  v;
		v = longint'($signed(it.value));
		if (n_taken >= MAX_ITEMS) begin
			// Array already full: drop the value, only flag it.
			ovf_seen = 1'b1;
		end else begin
			if (n_taken == 0) begin
				hi_val = v;
				lo_val = v;
				hi_pos = 0;
				lo_pos = 0;
			end else begin
				// Strict compares keep the first occurrence on ties.
				if (v > hi_val) begin
					hi_val = v;
					hi_pos = n_taken;
				end
				if (v < lo_val) begin
					lo_val = v;
					lo_pos = n_taken;
				end
			end
			sum_acc += v;
			n_taken++;
		end
		if (it.last) begin
			// SV signed division truncates toward zero, same as the block.
			r.mean        = 32'(sum_acc / n_taken);
			r.max_value   = 32'(hi_val);
			r.max_idx     = (hi_pos > 65535) ? 16'hffff : 16'(hi_pos);
			r.min_value   = 32'(lo_val);
			r.min_idx     = (lo_pos > 65535) ? 16'hffff : 16'(lo_pos);
			r.value_range = 32'(hi_val - lo_val);
			r.overflow    = ovf_seen;
			stats_q.push_back(r);
			sum_acc = 0;
			hi_val = 0;
			lo_val = 0;
			hi_pos = 0;
			lo_pos = 0;
			n_taken = 0;
			ovf_seen = 1'b0;
		end
	endfunction

	function automatic void push_item(logic signed [VALUE_W-1:0] v, bit is_last);
		item_t it;
		it.value = v;
		it.last  = is_last;
		pending_q.push_back(it);
		values_queued++;
		if (is_last)
			arrays_queued++;
	endfunction

	// Draw one value; the flavor biases toward ties, corners or wide values.
	function automatic logic signed [VALUE_W-1:0] draw_value(int flavor);
		if ($urandom_range(7) == 0)
			return $urandom;
		case (flavor)
			0: return $urandom;
			1: return $signed(32'($urandom_range(8))) - 4;
			2: begin
				case ($urandom_range(4))
					0: return S32_MIN;
					1: return S32_MAX;
					2: return 0;
					3: return -1;
					default: return 1;
				endcase
			end
			default: begin
				if ($urandom_range(1))
					return S32_MAX - $signed(32'($urandom_range(255)));
				return S32_MIN + $signed(32'($urandom_range(255)));
			end
		endcase
	endfunction

	// Queue random arrays until the phase has its share of values. Keep most
	// arrays short so many results come back; a few run longer.
	task automatic queue_random_arrays();
		int target;
		int len;
		int flavor;
		target = values_queued + RANDOM_PER_PHASE;
		while (values_queued < target) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			flavor = $urandom_range(3);
			for (int k = 0; k < len; k++)
				push_item(draw_value(flavor), k == len - 1);
		end
	endtask

	// Hold until every queued beat is taken and every result has come back.
	task automatic drain_all();
		while (pending_q.size() != 0 || item_ch.valid || stats_q.size() != 0)
			@(posedge clk);
	endtask

	// Sender: advance to the next beat once the current one is taken, or idle.
	always @(negedge clk) begin
		if (!item_ch.valid || item_beat) begin
			if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item_ch.data  <= pending_q.pop_front();
				item_ch.valid <= 1'b1;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: stall at random at the phase's rate.
	always @(negedge clk)
		result_ch.ready <= ($urandom_range(99) >= stall_pct);

	// Monitor: check results, feed accepted beats to the predictor, and keep
	// the hang counter.
	always @(posedge clk) begin
		item_beat <= item_ch.valid && item_ch.ready;
		if (result_ch.valid && result_ch.ready) begin
			if (stats_q.size() == 0) begin
				err_count++;
				if (err_shown < 10) begin
					err_shown++;
					$display("unexpected result beat: mean %0d max %0d min %0d",
						result_ch.data.mean, result_ch.data.max_value,
						result_ch.data.min_value);
				end
			end else begin
				result_t want;
				result_t got;
				want = stats_q.pop_front();
				got  = result_ch.data;
				results_checked++;
				if (got.mean !== want.mean || got.max_value !== want.max_value ||
						got.max_idx !== want.max_idx ||
						got.min_value !== want.min_value ||
						got.min_idx !== want.min_idx ||
						got.value_range !== want.value_range ||
						got.overflow !== want.overflow) begin
					err_count++;
					if (err_shown < 10) begin
						err_shown++;
						$display("result %0d mismatch (expected / actual):", results_checked);
						$display("  mean %0d / %0d  max %0d@%0d / %0d@%0d",
							want.mean, got.mean, want.max_value, want.max_idx,
							got.max_value, got.max_idx);
						$display("  min %0d@%0d / %0d@%0d  range %h / %h  ovf %b / %b",
							want.min_value, want.min_idx, got.min_value, got.min_idx,
							want.value_range, got.value_range, want.overflow, got.overflow);
					end
				end
			end
		end
		if (item_ch.valid && item_ch.ready)
			fold_value(item_ch.data);
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Watchdog: end the run if nothing moves for too long.
	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("no beat for %0d cycles, %0d results outstanding",
			QUIET_LIMIT, stats_q.size());
		$display("simulation failed");
		$finish;
	end

	initial begin
		item_ch.valid   = 1'b0;
		item_ch.data    = '0;
		result_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Phase with no idling: directed arrays first.
		// Single-element arrays at zero and at both extremes.
		push_item(0, 1'b1);
		push_item(S32_MAX, 1'b1);
		push_item(S32_MIN, 1'b1);
		// Full range; sum -1 over two truncates to zero.
		push_item(S32_MIN, 1'b0); push_item(S32_MAX, 1'b1);
		// Negative mean truncates toward zero, not down.
		push_item(-1, 1'b0); push_item(-2, 1'b1);
		// Ties everywhere: indices stay at the first occurrence.
		push_item(5, 1'b0); push_item(5, 1'b0); push_item(5, 1'b1);
		push_item(3, 1'b0); push_item(-3, 1'b0); push_item(3, 1'b0);
		push_item(-3, 1'b0); push_item(7, 1'b0); push_item(-7, 1'b1);
		push_item(-7, 1'b0); push_item(0, 1'b0); push_item(0, 1'b1);

		// Long array of large values: min sits at the last index.
		for (int k = 0; k < LONG_LEN; k++)
			push_item((k == LONG_LEN - 1) ? S32_MIN : S32_MAX, k == LONG_LEN - 1);
		queue_random_arrays();
		drain_all();

		// Sender mostly idle.
		send_idle_pct = 85;
		stall_pct = 0;
		queue_random_arrays();
		drain_all();

		// Receiver mostly stalled.
		send_idle_pct = 0;
		stall_pct = 85;
		queue_random_arrays();
		drain_all();

		// Light idling on both sides.
		send_idle_pct = 8;
		stall_pct = 8;
		queue_random_arrays();
		drain_all();

		send_idle_pct = 0;
		stall_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d arrays, %0d values: extremes, ties, truncation and long",
			arrays_queued, values_queued);
		$display("arrays under four idle/stall mixes; %0d results checked, %0d errors",
			results_checked, err_count);
		if (err_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
src/amms_pkg.sv
src/amms_if.sv
src/array_min_max_mean_stats.sv
src/amms_checker.sv
tb/tb_top.sv
